// ----- sv/gpc_pkg.sv -----
package gpc_pkg;

  // Default sizing of the block
  localparam int DEF_MAX_COLUMNS = 1024;
  localparam int DEF_COUNT_BITS  = 32;

  // Width of one adder cell of the count chain
  localparam int SLICE_BITS = 8;

  // Fixed field widths on the ports
  localparam int ROW_WIDTH_BITS  = 11;
  localparam int PATH_COUNT_BITS = 32;
  localparam int IN_TDATA_BITS   = 8;

endpackage

// ----- sv/gpc_cell.sv -----
// One slice of the count adder. The cell keeps its slice of the left
// count and adds the matching slice of the above count, passing the
// carry on to the next cell of the chain.
module gpc_cell (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            load,
  input  logic                            clear,
  input  logic [gpc_pkg::SLICE_BITS-1:0]  count_slice,
  input  logic [gpc_pkg::SLICE_BITS-1:0]  above_slice,
  input  logic                            carry_in,
  output logic [gpc_pkg::SLICE_BITS-1:0]  sum_slice,
  output logic                            carry_out
);

  logic [gpc_pkg::SLICE_BITS-1:0] left_slice;
  logic [gpc_pkg::SLICE_BITS:0]   sum_wide;

  // Add this slice with the carry from the lower neighbor
  assign sum_wide  = {1'b0, left_slice} + {1'b0, above_slice}
                   + {{gpc_pkg::SLICE_BITS{1'b0}}, carry_in};
  assign sum_slice = sum_wide[gpc_pkg::SLICE_BITS-1:0];
  assign carry_out = sum_wide[gpc_pkg::SLICE_BITS];

  // Hold the left count slice; clear it at a row or grid end
  always_ff @(posedge clk) begin
    if (rst) begin
      left_slice <= '0;
    end else if (load) begin
      left_slice <= clear ? '0 : count_slice;
    end
  end

endmodule

// ----- sv/gpc_row_buffer.sv -----
// Row of counts from the previous grid row. The entry for the next word
// is fetched when the current word is accepted; a fetch from the column
// being written in the same cycle takes the new value instead.
module gpc_row_buffer #(
  parameter int DEPTH = gpc_pkg::DEF_MAX_COLUMNS,
  parameter int AW    = 10,
  parameter int DW    = gpc_pkg::DEF_COUNT_BITS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_q;
  logic [DW-1:0] fwd_data;
  logic          fwd_hit;

  // Write the current count and fetch the next column
  always_ff @(posedge clk) begin
    if (en) begin
      mem[wr_addr] <= wr_data;
      rd_q         <= mem[rd_addr];
      fwd_data     <= wr_data;
    end
  end

  // Track a fetch that collides with the write
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (en) begin
      fwd_hit <= (rd_addr == wr_addr);
    end
  end

  assign rd_data = fwd_hit ? fwd_data : rd_q;

endmodule

// ----- sv/grid_path_count_with_obstacles.sv -----
// A result word appears on the master side in the cycle after its input
// word is accepted. The block takes one word per cycle while the master side
// does not stall, set by the loop through the left count held in the adder cells and the row buffer port.
// Reset clears position, left count, row state, overflow flag, width (to 1)
// and the output valid flag; the row buffer is not cleared.
module grid_path_count_with_obstacles #(
  parameter int MAX_COLUMNS = gpc_pkg::DEF_MAX_COLUMNS,
  parameter int COUNT_BITS  = gpc_pkg::DEF_COUNT_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // config write: row_width
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [gpc_pkg::ROW_WIDTH_BITS-1:0]    cfg_data,
  // slave side
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [gpc_pkg::IN_TDATA_BITS-1:0]     s_tdata,   // [0] blocked, [7:1] zero
  input  logic                                  s_tlast,   // final_cell
  // master side
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [gpc_pkg::PATH_COUNT_BITS-1:0]   m_tdata,   // [31:0] path_count
  output logic                                  m_tuser,   // [0] overflowed
  output logic                                  m_tlast    // is_final
);

  localparam int COL_BITS = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int CMP_BITS = (COL_BITS + 1 > gpc_pkg::ROW_WIDTH_BITS)
                          ? COL_BITS + 1 : gpc_pkg::ROW_WIDTH_BITS;
  localparam int NCELLS   = (COUNT_BITS + gpc_pkg::SLICE_BITS - 1) / gpc_pkg::SLICE_BITS;
  localparam int PAD_BITS = NCELLS * gpc_pkg::SLICE_BITS;
  localparam logic [PAD_BITS-1:0] COUNT_MASK = {PAD_BITS{1'b1}} >> (PAD_BITS - COUNT_BITS);
  localparam logic [PAD_BITS-1:0] ONE_PAD    = PAD_BITS'(1);

  // Registers
  logic [gpc_pkg::ROW_WIDTH_BITS-1:0] row_width;
  logic [COL_BITS-1:0]                col;
  logic                               first_row;
  logic                               overflow_seen;

  // Datapath
  logic                  accept;
  logic                  blocked;
  logic                  fin;
  logic [CMP_BITS-1:0]   width_raw;
  logic [CMP_BITS-1:0]   width_eff;
  logic [CMP_BITS-1:0]   col_plus;
  logic                  wrap;
  logic [COL_BITS-1:0]   col_next;
  logic [PAD_BITS-1:0]   above_raw;
  logic [PAD_BITS-1:0]   above;
  logic [PAD_BITS-1:0]   sum;
  logic [NCELLS:0]       carry;
  logic                  sat;
  logic                  origin;
  logic [PAD_BITS-1:0]   count;
  logic                  overflow_now;
  logic [PAD_BITS+gpc_pkg::PATH_COUNT_BITS-1:0] count_ext;

  assign cfg_ready = 1'b1;
  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign blocked   = s_tdata[0];
  assign fin       = s_tlast;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      row_width <= gpc_pkg::ROW_WIDTH_BITS'(1);
    end else if (cfg_valid && cfg_ready) begin
      row_width <= cfg_data;
    end
  end

  // Clamp the width into 1..MAX_COLUMNS
  always_comb begin
    width_raw = CMP_BITS'(row_width);
    if (width_raw == '0) begin
      width_eff = CMP_BITS'(1);
    end else if (width_raw > CMP_BITS'(MAX_COLUMNS)) begin
      width_eff = CMP_BITS'(MAX_COLUMNS);
    end else begin
      width_eff = width_raw;
    end
  end

  // Advance the column
  assign col_plus = CMP_BITS'(col) + CMP_BITS'(1);
  assign wrap     = (col_plus >= width_eff);
  assign col_next = (fin || wrap) ? '0 : col_plus[COL_BITS-1:0];

  // Row of counts from the row above
  gpc_row_buffer #(
    .DEPTH (MAX_COLUMNS),
    .AW    (COL_BITS),
    .DW    (PAD_BITS)
  ) u_row (
    .clk     (clk),
    .rst     (rst),
    .en      (accept),
    .wr_addr (col),
    .wr_data (count),
    .rd_addr (col_next),
    .rd_data (above_raw)
  );

  assign above = first_row ? '0 : above_raw;

  // Chain of adder cells holding the left count
  assign carry[0] = 1'b0;
  for (genvar i = 0; i < NCELLS; i++) begin : g_cell
    gpc_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .load        (accept),
      .clear       (fin || wrap),
      .count_slice (count[i*gpc_pkg::SLICE_BITS +: gpc_pkg::SLICE_BITS]),
      .above_slice (above[i*gpc_pkg::SLICE_BITS +: gpc_pkg::SLICE_BITS]),
      .carry_in    (carry[i]),
      .sum_slice   (sum[i*gpc_pkg::SLICE_BITS +: gpc_pkg::SLICE_BITS]),
      .carry_out   (carry[i+1])
    );
  end

  // Pick the count of this cell and saturate
  assign sat    = carry[NCELLS] || ((sum & ~COUNT_MASK) != '0);
  assign origin = first_row && (col == '0);

  always_comb begin
    overflow_now = overflow_seen;
    if (blocked) begin
      count = '0;
    end else if (origin) begin
      count = ONE_PAD;
    end else if (sat) begin
      count        = COUNT_MASK;
      overflow_now = 1'b1;
    end else begin
      count = sum;
    end
  end

  // Update position and grid state
  always_ff @(posedge clk) begin
    if (rst) begin
      col           <= '0;
      first_row     <= 1'b1;
      overflow_seen <= 1'b0;
    end else if (accept) begin
      col <= col_next;
      if (fin) begin
        first_row     <= 1'b1;
        overflow_seen <= 1'b0;
      end else begin
        overflow_seen <= overflow_now;
        if (wrap) begin
          first_row <= 1'b0;
        end
      end
    end
  end

  assign count_ext = {{gpc_pkg::PATH_COUNT_BITS{1'b0}}, count};

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= count_ext[gpc_pkg::PATH_COUNT_BITS-1:0];
      m_tuser <= overflow_now;
      m_tlast <= fin;
    end
  end

endmodule
